// File: rtl/core/assert_macros.svh
// Assertion macros for the point rotation RTL; only prc_post includes them.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("concurrent assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("concurrent assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: rtl/core/prc_pkg.sv
// Shared widths, angle constants, arctangent table and stage structs
// for the point rotation pipeline. No dependencies.
package prc_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = 25;
    localparam int ANG_IN_W   = 26;
    localparam int ANG_W      = 27;
    localparam int CORD_W     = 32;
    localparam int PROD_W     = 57;
    localparam int ROT_W      = 28;
    localparam int Q_FRAC     = 30;
    localparam int Z_SHIFT    = 8;
    localparam int TABLE_LEN  = 24;
    localparam int DEF_STAGES = 16;

    localparam logic signed [ANG_W-1:0] ANG_FULL  = 27'sd23592960;
    localparam logic signed [ANG_W-1:0] ANG_HALF  = 27'sd11796480;
    localparam logic signed [ANG_W-1:0] ANG_QUART = 27'sd5898240;
    localparam logic signed [ANG_W-1:0] ANG_SMALL = 27'sd65;

    localparam logic signed [CORD_W-1:0] GAIN_Q30 = 32'sd652032874;

    // atan(2^-i) in units of 2^-24 degree
    localparam logic signed [CORD_W-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115
    };

    typedef struct packed {
        logic valid;
        logic bypass;
    } t_side;

    typedef struct packed {
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } t_geom;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [CORD_W-1:0] z;
    } t_cord;

endpackage

// File: rtl/core/prc_prep.sv
// Front end: angle negate, small-angle test, reduction to +-90 degrees,
// centre offsets and CORDIC seed. Three register stages. Uses prc_pkg.
module prc_prep import prc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [COORD_W-1:0]  i_point_x,
    input  logic signed [COORD_W-1:0]  i_point_y,
    input  logic signed [COORD_W-1:0]  i_center_x,
    input  logic signed [COORD_W-1:0]  i_center_y,
    input  logic signed [ANG_IN_W-1:0] i_angle_deg,
    input  logic                       i_reverse,
    output t_side                      o_side,
    output t_geom                      o_geom,
    output t_cord                      o_cord
);

    logic                    r_v1, r_v2;
    logic                    r_bp2;
    logic signed [ANG_W-1:0] r_a1, r_a2;
    t_geom                   r_geom1, r_geom2, r_geom3;
    t_side                   r_side3;
    t_cord                   r_cord3;

    logic signed [ANG_W-1:0] n_a1, n_a2, a_fold;
    logic                    n_bp2, flip;
    t_geom                   n_geom1, n_geom3;
    t_cord                   n_cord3;

    always_comb begin
        n_a1       = i_reverse ? -ANG_W'(i_angle_deg) : ANG_W'(i_angle_deg);
        n_geom1.dx = DIFF_W'(i_point_x) - DIFF_W'(i_center_x);
        n_geom1.dy = DIFF_W'(i_point_y) - DIFF_W'(i_center_y);
        n_geom1.cx = i_center_x;
        n_geom1.cy = i_center_y;
    end

    always_comb begin
        n_bp2 = (r_a1 >= -ANG_SMALL) && (r_a1 <= ANG_SMALL);
        priority if (r_a1 >= ANG_HALF) begin
            n_a2 = r_a1 - ANG_FULL;
        end else if (r_a1 < -ANG_HALF) begin
            n_a2 = r_a1 + ANG_FULL;
        end else begin
            n_a2 = r_a1;
        end
    end

    // fold into +-90; negating the offsets stands in for negating sin and cos
    always_comb begin
        priority if (r_a2 > ANG_QUART) begin
            a_fold = r_a2 - ANG_HALF;
            flip   = !r_bp2;
        end else if (r_a2 < -ANG_QUART) begin
            a_fold = r_a2 + ANG_HALF;
            flip   = !r_bp2;
        end else begin
            a_fold = r_a2;
            flip   = 1'b0;
        end
        n_geom3    = r_geom2;
        if (flip) begin
            n_geom3.dx = -r_geom2.dx;
            n_geom3.dy = -r_geom2.dy;
        end
        n_cord3.x = GAIN_Q30;
        n_cord3.y = '0;
        n_cord3.z = CORD_W'(a_fold) <<< Z_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_side3 <= '0;
        end else begin
            r_v1          <= i_valid;
            r_v2          <= r_v1;
            r_side3.valid <= r_v2;
            r_side3.bypass <= r_bp2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1    <= n_a1;
        r_geom1 <= n_geom1;
        r_a2    <= n_a2;
        r_bp2   <= n_bp2;
        r_geom2 <= r_geom1;
        r_geom3 <= n_geom3;
        r_cord3 <= n_cord3;
    end

    assign o_side = r_side3;
    assign o_geom = r_geom3;
    assign o_cord = r_cord3;

endmodule

// File: rtl/core/prc_cell.sv
// One CORDIC rotation cell: a micro-rotation by atan(2^-IDX), passing the
// word and its side data on to the next cell. Uses prc_pkg.
module prc_cell import prc_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_side i_side,
    input  t_geom i_geom,
    input  t_cord i_cord,
    output t_side o_side,
    output t_geom o_geom,
    output t_cord o_cord
);

    logic signed [CORD_W-1:0] x, y, z, xs, ys;
    t_cord                    n_cord;
    t_side                    r_side;
    t_geom                    r_geom;
    t_cord                    r_cord;

    always_comb begin
        x  = i_cord.x;
        y  = i_cord.y;
        z  = i_cord.z;
        xs = x >>> IDX;
        ys = y >>> IDX;
        if (z >= 0) begin
            n_cord.x = x - ys;
            n_cord.y = y + xs;
            n_cord.z = z - ATAN_TAB[IDX];
        end else begin
            n_cord.x = x + ys;
            n_cord.y = y - xs;
            n_cord.z = z + ATAN_TAB[IDX];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_geom <= i_geom;
        r_cord <= n_cord;
    end

    assign o_side = r_side;
    assign o_geom = r_geom;
    assign o_cord = r_cord;

endmodule

// File: rtl/core/prc_post.sv
// Back end: offset times cos/sin (offset as is when bypassed), round, add
// centre back and saturate. Three register stages. Uses prc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module prc_post import prc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_side                     i_side,
    input  t_geom                     i_geom,
    input  t_cord                     i_cord,
    output logic                      o_valid,
    output logic signed [COORD_W-1:0] o_out_x,
    output logic signed [COORD_W-1:0] o_out_y,
    output logic                      o_bypassed
);

    localparam logic signed [PROD_W:0]  RND  = (PROD_W+1)'(1) <<< (Q_FRAC - 1);
    localparam logic signed [ROT_W:0]   SMAX = (ROT_W+1)'(2 ** (COORD_W - 1) - 1);
    localparam logic signed [ROT_W:0]   SMIN = -(ROT_W+1)'(2 ** (COORD_W - 1));

    logic                     r_v1, r_v2, r_v3;
    logic                     r_bp1, r_bp2, r_bp3;
    logic signed [PROD_W-1:0] r_xc, r_ys, r_xs, r_yc;
    t_geom                    r_geom1;
    logic signed [COORD_W-1:0] r_cx2, r_cy2;
    logic signed [ROT_W-1:0]  r_rx, r_ry;
    logic signed [COORD_W-1:0] r_ox, r_oy;

    logic signed [PROD_W:0]   sum_x, sum_y, sh_x, sh_y;
    logic signed [ROT_W-1:0]  n_rx, n_ry;
    logic signed [ROT_W:0]    tot_x, tot_y;
    logic signed [COORD_W-1:0] n_ox, n_oy;

    always_comb begin
        sum_x = (PROD_W+1)'(r_xc) - (PROD_W+1)'(r_ys) + RND;
        sum_y = (PROD_W+1)'(r_xs) + (PROD_W+1)'(r_yc) + RND;
        sh_x  = sum_x >>> Q_FRAC;
        sh_y  = sum_y >>> Q_FRAC;
        if (r_bp1) begin
            n_rx = ROT_W'(r_geom1.dx);
            n_ry = ROT_W'(r_geom1.dy);
        end else begin
            n_rx = sh_x[ROT_W-1:0];
            n_ry = sh_y[ROT_W-1:0];
        end
    end

    always_comb begin
        tot_x = (ROT_W+1)'(r_rx) + (ROT_W+1)'(r_cx2);
        tot_y = (ROT_W+1)'(r_ry) + (ROT_W+1)'(r_cy2);
        priority if (tot_x > SMAX) begin
            n_ox = SMAX[COORD_W-1:0];
        end else if (tot_x < SMIN) begin
            n_ox = SMIN[COORD_W-1:0];
        end else begin
            n_ox = tot_x[COORD_W-1:0];
        end
        priority if (tot_y > SMAX) begin
            n_oy = SMAX[COORD_W-1:0];
        end else if (tot_y < SMIN) begin
            n_oy = SMIN[COORD_W-1:0];
        end else begin
            n_oy = tot_y[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_side.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xc    <= PROD_W'(i_geom.dx) * PROD_W'(i_cord.x);
        r_ys    <= PROD_W'(i_geom.dy) * PROD_W'(i_cord.y);
        r_xs    <= PROD_W'(i_geom.dx) * PROD_W'(i_cord.y);
        r_yc    <= PROD_W'(i_geom.dy) * PROD_W'(i_cord.x);
        r_geom1 <= i_geom;
        r_bp1   <= i_side.bypass;
        r_rx    <= n_rx;
        r_ry    <= n_ry;
        r_cx2   <= r_geom1.cx;
        r_cy2   <= r_geom1.cy;
        r_bp2   <= r_bp1;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_bp3   <= r_bp2;
    end

    assign o_valid    = r_v3;
    assign o_out_x    = r_ox;
    assign o_out_y    = r_oy;
    assign o_bypassed = r_bp3;

    `ASSERT_CLK(a_valid_follow, i_clk, i_rst_n, o_valid |-> $past(r_v2))
    `ASSERT_CLK(a_bypass_follow, i_clk, i_rst_n, o_valid |-> (o_bypassed == $past(r_bp2)))
    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid)

endmodule

// File: rtl/core/point_rotate_about_center.sv
// Top level of the point rotation block: front end, CORDIC cell chain
// and back end. Uses prc_pkg, prc_prep, prc_cell and prc_post.
//
// Rotates a point about a centre by an angle in 1/65536 degree units
// (negated when reverse is set). One word is taken every clock: busy is
// always low. Each result passes three front-end stages, one cell per CORDIC
// stage and three back-end stages, and is shown on the outputs for one cycle
// with o_valid high; the receiver must take it then, as the pipeline cannot
// be held.
module point_rotate_about_center import prc_pkg::*; #(
    parameter int CORDIC_STAGES = DEF_STAGES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [COORD_W-1:0]  i_point_x,
    input  logic signed [COORD_W-1:0]  i_point_y,
    input  logic signed [COORD_W-1:0]  i_center_x,
    input  logic signed [COORD_W-1:0]  i_center_y,
    input  logic signed [ANG_IN_W-1:0] i_angle_deg,
    input  logic                       i_reverse,
    output logic                       o_valid,
    output logic signed [COORD_W-1:0]  o_out_x,
    output logic signed [COORD_W-1:0]  o_out_y,
    output logic                       o_bypassed
);

    t_side side_c [0:CORDIC_STAGES];
    t_geom geom_c [0:CORDIC_STAGES];
    t_cord cord_c [0:CORDIC_STAGES];

    assign busy = 1'b0;

    prc_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start && !busy),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_angle_deg (i_angle_deg),
        .i_reverse   (i_reverse),
        .o_side      (side_c[0]),
        .o_geom      (geom_c[0]),
        .o_cord      (cord_c[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        prc_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (side_c[g]),
            .i_geom  (geom_c[g]),
            .i_cord  (cord_c[g]),
            .o_side  (side_c[g+1]),
            .o_geom  (geom_c[g+1]),
            .o_cord  (cord_c[g+1])
        );
    end

    prc_post u_post (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_side     (side_c[CORDIC_STAGES]),
        .i_geom     (geom_c[CORDIC_STAGES]),
        .i_cord     (cord_c[CORDIC_STAGES]),
        .o_valid    (o_valid),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_bypassed (o_bypassed)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for point_rotate_about_center: a CORDIC rotation predictor
// checks every output word. Depends on prc_pkg and the point_rotate_about_center RTL.
module tb_top;
    import prc_pkg::COORD_W;
    import prc_pkg::ANG_IN_W;

    localparam int    N_STAGES      = 16;
    localparam int    WATCHDOG_MAX  = 4000;
    localparam int    CMAX          = 8388607;
    localparam int    CMIN          = -8388608;
    localparam int    TURN          = 23592960;
    localparam int    HALF_TURN     = 11796480;
    localparam int    QUARTER_TURN  = 5898240;
    localparam int    SMALL_ANGLE   = 65;
    localparam longint GAIN_Q30     = 652032874;
    localparam longint ROUND_Q30    = 64'sd536870912;

    typedef struct {
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic signed [ANG_IN_W-1:0] ang;
        logic                       rev;
    } t_point_word;

    typedef struct {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      bypassed;
    } t_rot_word;

    // atan(2^-i), 2^-24 degree units
    longint atan_lut [0:23] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       start       = 1'b0;
    logic signed [COORD_W-1:0]  i_point_x   = '0;
    logic signed [COORD_W-1:0]  i_point_y   = '0;
    logic signed [COORD_W-1:0]  i_center_x  = '0;
    logic signed [COORD_W-1:0]  i_center_y  = '0;
    logic signed [ANG_IN_W-1:0] i_angle_deg = '0;
    logic                       i_reverse   = 1'b0;
    logic                       busy;
    logic                       o_valid;
    logic signed [COORD_W-1:0]  o_out_x;
    logic signed [COORD_W-1:0]  o_out_y;
    logic                       o_bypassed;

    t_rot_word expected_points [$];
    t_rot_word want_word;
    int        err_count       = 0;
    int        words_sent      = 0;
    int        results_checked = 0;
    int        bypass_count    = 0;
    int        sender_idle_pct = 0;
    int        idle_cycles     = 0;

    point_rotate_about_center #(
        .CORDIC_STAGES(N_STAGES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_angle_deg(i_angle_deg),
        .i_reverse  (i_reverse),
        .o_valid    (o_valid),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_bypassed (o_bypassed)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
        if (v > CMAX) return COORD_W'(CMAX);
        if (v < CMIN) return COORD_W'(CMIN);
        return COORD_W'(v);
    endfunction

    function automatic t_rot_word rotate_about_center(input t_point_word w);
        t_rot_word r;
        longint    ang, c, s, z, xs, ys, dx, dy;
        bit        flip;
        int        i;
        ang  = longint'(w.ang);
        flip = 1'b0;
        if (w.rev)
            ang = -ang;
        if (ang >= -SMALL_ANGLE && ang <= SMALL_ANGLE) begin
            r.out_x    = w.px;
            r.out_y    = w.py;
            r.bypassed = 1'b1;
            return r;
        end
        ang = ang % TURN;
        if (ang >= HALF_TURN)
            ang -= TURN;
        if (ang < -HALF_TURN)
            ang += TURN;
        if (ang > QUARTER_TURN) begin
            ang -= HALF_TURN;
            flip = 1'b1;
        end else if (ang < -QUARTER_TURN) begin
            ang += HALF_TURN;
            flip = 1'b1;
        end
        c = GAIN_Q30;
        s = 0;
        z = ang * 256;
        for (i = 0; i < N_STAGES; i++) begin
            xs = c >>> i;
            ys = s >>> i;
            if (z >= 0) begin
                c = c - ys;
                s = s + xs;
                z = z - atan_lut[i];
            end else begin
                c = c + ys;
                s = s - xs;
                z = z + atan_lut[i];
            end
        end
        if (flip) begin
            c = -c;
            s = -s;
        end
        dx = longint'(w.px) - longint'(w.cx);
        dy = longint'(w.py) - longint'(w.cy);
        r.out_x    = clamp_coord(((dx * c - dy * s + ROUND_Q30) >>> 30) + longint'(w.cx));
        r.out_y    = clamp_coord(((dx * s + dy * c + ROUND_Q30) >>> 30) + longint'(w.cy));
        r.bypassed = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic send_point(input t_point_word w);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_point_x   <= w.px;
        i_point_y   <= w.py;
        i_center_x  <= w.cx;
        i_center_y  <= w.cy;
        i_angle_deg <= w.ang;
        i_reverse   <= w.rev;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        expected_points.push_back(rotate_about_center(w));
        words_sent++;
    endtask

    task automatic send_fields(input int px, input int py, input int cx, input int cy,
                               input int ang, input bit rev);
        t_point_word w;
        w.px  = COORD_W'(px);
        w.py  = COORD_W'(py);
        w.cx  = COORD_W'(cx);
        w.cy  = COORD_W'(cy);
        w.ang = ANG_IN_W'(ang);
        w.rev = rev;
        send_point(w);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(3))
            0:       return COORD_W'($urandom);
            1:       return COORD_W'($urandom_range(8192) - 4096);
            2:       return $urandom_range(1) ? COORD_W'(CMAX - $urandom_range(3))
                                              : COORD_W'(CMIN + $urandom_range(3));
            default: return COORD_W'($urandom_range(2097152) - 1048576);
        endcase
    endfunction

    function automatic logic signed [ANG_IN_W-1:0] rand_angle();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return ANG_IN_W'($urandom_range(2 * TURN) - TURN);
            5, 6:          return ANG_IN_W'($urandom_range(200) - 100);
            7, 8:          return ANG_IN_W'(($urandom_range(8) - 4) * QUARTER_TURN
                                            + $urandom_range(6) - 3);
            default:       return $urandom_range(1) ? ANG_IN_W'(TURN - $urandom_range(100))
                                                    : ANG_IN_W'(-TURN + $urandom_range(100));
        endcase
    endfunction

    // threshold edges, reverse on tiny angles, extreme coordinates through the bypass
    task automatic test_small_angle();
        send_fields(CMAX, CMIN, 0, 0, 0, 1'b0);
        send_fields(1000, -2000, 50, 60, 65, 1'b0);
        send_fields(CMIN, CMAX, 7, -7, -65, 1'b0);
        send_fields(1000, -2000, 50, 60, 66, 1'b0);
        send_fields(1000, -2000, 50, 60, -66, 1'b0);
        send_fields(-300, 400, 0, 0, 65, 1'b1);
        send_fields(-300, 400, 0, 0, -66, 1'b1);
    endtask

    // modulo-360 reduction and quadrant folding
    task automatic test_angle_wrap();
        send_fields(25600, 12800, 256, -512, TURN, 1'b0);
        send_fields(25600, 12800, 256, -512, -TURN, 1'b0);
        send_fields(25600, 12800, 256, -512, HALF_TURN, 1'b0);
        send_fields(25600, 12800, 256, -512, -HALF_TURN, 1'b0);
        send_fields(-9000, 3000, 100, 100, QUARTER_TURN, 1'b0);
        send_fields(-9000, 3000, 100, 100, -QUARTER_TURN, 1'b0);
        send_fields(-9000, 3000, 100, 100, QUARTER_TURN + 1, 1'b1);
        send_fields(40000, -40000, 0, 0, 3 * QUARTER_TURN, 1'b0);
        send_fields(40000, -40000, 0, 0, TURN - 66, 1'b0);
        send_fields(40000, -40000, 0, 0, QUARTER_TURN / 2, 1'b1);
    endtask

    // offsets large enough to clip the outputs
    task automatic test_saturation();
        send_fields(CMAX, CMAX, CMIN, CMIN, HALF_TURN, 1'b0);
        send_fields(CMIN, CMIN, CMAX, CMAX, HALF_TURN, 1'b0);
        send_fields(CMAX, CMIN, CMIN, CMAX, QUARTER_TURN, 1'b0);
        send_fields(CMIN, CMAX, CMAX, CMIN, QUARTER_TURN, 1'b1);
        send_fields(CMAX, CMAX, CMAX, CMAX, QUARTER_TURN / 3, 1'b0);
    endtask

    task automatic test_random_sweep(input int idle_pct, input int n_words);
        t_point_word w;
        sender_idle_pct = idle_pct;
        repeat (n_words) begin
            w.px  = rand_coord();
            w.py  = rand_coord();
            w.cx  = rand_coord();
            w.cy  = rand_coord();
            w.ang = rand_angle();
            w.rev = 1'($urandom_range(1));
            send_point(w);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_points.size() == 0) begin
                report_mismatch($sformatf("unexpected word x=%0d y=%0d", o_out_x, o_out_y));
            end else begin
                want_word = expected_points.pop_front();
                if (o_out_x !== want_word.out_x)
                    report_mismatch($sformatf("word %0d out_x got %0d want %0d",
                                              results_checked, o_out_x, want_word.out_x));
                if (o_out_y !== want_word.out_y)
                    report_mismatch($sformatf("word %0d out_y got %0d want %0d",
                                              results_checked, o_out_y, want_word.out_y));
                if (o_bypassed !== want_word.bypassed)
                    report_mismatch($sformatf("word %0d bypassed got %0b want %0b",
                                              results_checked, o_bypassed, want_word.bypassed));
                if (want_word.bypassed)
                    bypass_count++;
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("watchdog: no activity for %0d cycles", WATCHDOG_MAX);
            $display("point_rotate_about_center regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_small_angle();
        test_angle_wrap();
        test_saturation();
        test_random_sweep(21, 450);
        test_random_sweep(76, 450);
        test_random_sweep(0, 450);
        start <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (N_STAGES + 10) @(posedge i_clk);
        $display("%0d words sent, %0d results checked, %0d passed through unchanged",
                 words_sent, results_checked, bypass_count);
        $display("sender idle 21%%, 76%% then 0%%; %0d mismatches", err_count);
        if (err_count == 0)
            $display("point_rotate_about_center regression: pass");
        else
            $display("point_rotate_about_center regression: fail");
        $finish;
    end

endmodule
